### sv/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
  localparam int NUM_WIDTH = 32;
  localparam int WIDE = 2 * NUM_WIDTH + 1;
  localparam int CNT_W = $clog2(WIDE + 1);
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_CMP = 3'd4
  } mode_t;

  localparam logic [1:0] CMP_LT = 2'd0;
  localparam logic [1:0] CMP_EQ = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  typedef struct packed {
    logic [2:0] mode;
    logic a_neg;
    logic [NUM_WIDTH-1:0] a_mag;
    logic [NUM_WIDTH-1:0] a_den;
    logic b_neg;
    logic [NUM_WIDTH-1:0] b_mag;
    logic [NUM_WIDTH-1:0] b_den;
  } work_t;
endpackage
`default_nettype wire

### sv/rau_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rau_front (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire  [2:0]                  in_mode,
  input  wire  [rau_pkg::NUM_WIDTH-1:0] in_a_num,
  input  wire  [rau_pkg::NUM_WIDTH-1:0] in_a_den,
  input  wire  [rau_pkg::NUM_WIDTH-1:0] in_b_num,
  input  wire  [rau_pkg::NUM_WIDTH-1:0] in_b_den,
  output logic                        q_valid,
  input  wire                         q_pop,
  output rau_pkg::work_t              q_item
);
  import rau_pkg::*;

  work_t q_r [QDEPTH];
  logic  wp_r, rp_r;
  logic  [1:0] cnt_r;
  logic  push;
  work_t w;

  // sign and magnitude, divide swaps b
  always_comb begin
    logic [NUM_WIDTH-1:0] bm;
    logic bn;
    w.mode  = in_mode;
    w.a_neg = in_a_num[NUM_WIDTH-1];
    w.a_mag = w.a_neg ? NUM_WIDTH'(-in_a_num) : in_a_num;
    w.a_den = in_a_den;
    bn = in_b_num[NUM_WIDTH-1];
    bm = bn ? NUM_WIDTH'(-in_b_num) : in_b_num;
    w.b_neg = bn;
    if (in_mode == MODE_DIV) begin
      w.b_mag = in_b_den;
      w.b_den = bm;
    end else begin
      w.b_mag = bm;
      w.b_den = in_b_den;
    end
    if (w.a_mag == '0) w.a_neg = 1'b0;
    if (w.b_mag == '0) w.b_neg = 1'b0;
  end

  assign in_stall = (cnt_r == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= w;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QDEPTH)) else $error("queue count beyond depth");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(QDEPTH)) |-> in_stall) else $error("full queue not stalling");
`endif
endmodule
`default_nettype wire

### sv/rau_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rau_back (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           q_valid,
  output logic                          q_pop,
  input  rau_pkg::work_t                q_item,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [rau_pkg::NUM_WIDTH-1:0] out_res_num,
  output logic [rau_pkg::NUM_WIDTH-1:0] out_res_den,
  output logic [1:0]                    out_cmp_result,
  output logic                          out_overflow
);
  import rau_pkg::*;
  localparam int W = WIDE;

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RB, S_MUL, S_COMB, S_RR, S_OUT
  } state_t;
  typedef enum logic [2:0] {
    G_STRIP, G_ODDA, G_LOOP, G_SH, G_DIVN, G_DIVD, G_DONE
  } gst_t;

  state_t st_r;
  gst_t   g_r;
  work_t  it_r;
  logic [W-1:0] a_r, b_r, gk_r;
  logic [CNT_W-1:0] sh_r;
  logic [W-1:0] n_r, d_r;
  logic [W-1:0] rem_r, quo_r, dvd_r;
  logic [CNT_W-1:0] bit_r;
  logic neg_r;
  logic xneg_r, yneg_r;
  logic [W-1:0] xn_r, xd_r, yn_r, yd_r;
  logic [W-1:0] p_r, q_r, dd_r;
  logic [1:0] mph_r;
  logic [W-1:0] rn_r, rd_r;
  logic rneg_r;
  logic [1:0] cmp_r;

  logic [W-1:0] sub_ab, sub_ba;
  logic [W-1:0] rem_sh;
  logic rem_ge;
  logic [NUM_WIDTH-1:0] mul_a, mul_b;
  logic [2*NUM_WIDTH-1:0] mul_p;

  assign sub_ab = a_r - b_r;
  assign sub_ba = b_r - a_r;
  assign rem_sh = {rem_r[W-2:0], dvd_r[W-1]};
  assign rem_ge = rem_sh >= gk_r;
  assign mul_p  = mul_a * mul_b;

  always_comb begin
    unique case (mph_r)
      2'd0: begin mul_a = xn_r[NUM_WIDTH-1:0]; mul_b = yd_r[NUM_WIDTH-1:0]; end
      2'd1: begin mul_a = yn_r[NUM_WIDTH-1:0]; mul_b = xd_r[NUM_WIDTH-1:0]; end
      2'd2: begin
        mul_a = xd_r[NUM_WIDTH-1:0];
        mul_b = yd_r[NUM_WIDTH-1:0];
      end
      default: begin
        mul_a = xn_r[NUM_WIDTH-1:0];
        mul_b = yn_r[NUM_WIDTH-1:0];
      end
    endcase
  end

  assign q_pop = (st_r == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    logic [W-1:0] sn;
    logic sg, ovf;
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid <= 1'b0;
      g_r <= G_DONE;
    end else begin
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          it_r <= q_item;
          n_r <= W'(q_item.a_mag);
          d_r <= W'(q_item.a_den);
          neg_r <= q_item.a_neg;
          st_r <= S_RA;
          g_r <= G_STRIP;
          a_r <= W'(q_item.a_mag);
          b_r <= W'(q_item.a_den);
          sh_r <= '0;
        end
        S_RA, S_RB, S_RR: begin
          // binary gcd then two restoring divides
          if (d_r == '0) begin
            g_r <= G_DONE;
            n_r <= (n_r == '0) ? '0 : W'(1);
            if (n_r == '0) neg_r <= 1'b0;
          end else if (n_r == '0) begin
            g_r <= G_DONE;
            d_r <= W'(1);
            neg_r <= 1'b0;
          end else begin
            unique case (g_r)
              G_STRIP: if (!a_r[0] && !b_r[0]) begin
                a_r <= a_r >> 1; b_r <= b_r >> 1; sh_r <= sh_r + 1'b1;
              end else g_r <= G_ODDA;
              G_ODDA: if (!a_r[0]) a_r <= a_r >> 1; else g_r <= G_LOOP;
              G_LOOP: if (b_r == '0) begin
                gk_r <= a_r << sh_r;
                g_r <= G_DIVN;
                dvd_r <= n_r; rem_r <= '0; quo_r <= '0; bit_r <= CNT_W'(W);
              end else if (!b_r[0]) b_r <= b_r >> 1;
              else if (a_r > b_r) begin b_r <= sub_ab; a_r <= b_r; end
              else b_r <= sub_ba;
              G_DIVN, G_DIVD: if (bit_r != '0) begin
                rem_r <= rem_ge ? rem_sh - gk_r : rem_sh;
                quo_r <= {quo_r[W-2:0], rem_ge};
                dvd_r <= dvd_r << 1;
                bit_r <= bit_r - 1'b1;
              end else if (g_r == G_DIVN) begin
                n_r <= quo_r;
                g_r <= G_DIVD;
                dvd_r <= d_r; rem_r <= '0; quo_r <= '0; bit_r <= CNT_W'(W);
              end else begin
                d_r <= quo_r;
                g_r <= G_DONE;
              end
              default: ;
            endcase
          end
          if (g_r == G_DONE) begin
            if (st_r == S_RA) begin
              xn_r <= n_r; xd_r <= d_r; xneg_r <= neg_r;
              n_r <= W'(it_r.b_mag); d_r <= W'(it_r.b_den);
              neg_r <= (it_r.mode == MODE_SUB || it_r.mode == MODE_CMP)
                       ? (it_r.b_neg ^ (it_r.b_mag != '0)) : it_r.b_neg;
              a_r <= W'(it_r.b_mag); b_r <= W'(it_r.b_den);
              sh_r <= '0; g_r <= G_STRIP;
              st_r <= S_RB;
            end else if (st_r == S_RB) begin
              yn_r <= n_r; yd_r <= d_r; yneg_r <= neg_r;
              mph_r <= 2'd0;
              st_r <= S_MUL;
            end else begin
              rn_r <= n_r; rd_r <= d_r; rneg_r <= neg_r;
              st_r <= S_OUT;
            end
          end
        end
        S_MUL: begin
          unique case (mph_r)
            2'd0: begin p_r <= W'(mul_p); mph_r <= 2'd1; end
            2'd1: begin q_r <= W'(mul_p); mph_r <= 2'd2; end
            2'd2: begin dd_r <= W'(mul_p); mph_r <= 2'd3; end
            default: begin
              if (it_r.mode == MODE_MUL || it_r.mode == MODE_DIV) p_r <= W'(mul_p);
              st_r <= S_COMB;
            end
          endcase
        end
        S_COMB: begin
          cmp_r <= CMP_EQ;
          if (it_r.mode == MODE_ADD || it_r.mode == MODE_SUB ||
              it_r.mode == MODE_CMP) begin
            if (xd_r == '0 || yd_r == '0) begin
              if (xd_r != '0) begin rn_r <= yn_r; rneg_r <= yneg_r; end
              else if (yd_r != '0) begin rn_r <= xn_r; rneg_r <= xneg_r; end
              else if (xneg_r == yneg_r && xn_r == yn_r) begin
                rn_r <= xn_r; rneg_r <= xneg_r;
              end else begin rn_r <= '0; rneg_r <= 1'b0; end
              rd_r <= '0;
              if (it_r.mode == MODE_CMP) begin
                if ((xd_r == '0 && xn_r == '0) || (yd_r == '0 && yn_r == '0))
                  cmp_r <= CMP_EQ;
                else if (xd_r != '0) cmp_r <= yneg_r ? CMP_LT : CMP_GT;
                else if (yd_r != '0 || xneg_r == yneg_r)
                  cmp_r <= xneg_r ? CMP_LT : CMP_GT;
                else cmp_r <= CMP_EQ;
              end
              st_r <= S_OUT;
            end else begin
              if (xneg_r == yneg_r) begin sn = p_r + q_r; sg = xneg_r; end
              else if (p_r >= q_r) begin sn = p_r - q_r; sg = xneg_r; end
              else begin sn = q_r - p_r; sg = yneg_r; end
              if (it_r.mode == MODE_CMP) begin
                cmp_r <= (sn == '0) ? CMP_EQ : (sg ? CMP_LT : CMP_GT);
                st_r <= S_OUT;
              end else begin
                n_r <= sn; d_r <= dd_r; neg_r <= sg;
                a_r <= sn; b_r <= dd_r; sh_r <= '0; g_r <= G_STRIP;
                st_r <= S_RR;
              end
            end
          end else if (it_r.mode == MODE_MUL || it_r.mode == MODE_DIV) begin
            if (xd_r == '0 || yd_r == '0) begin
              rd_r <= '0;
              if (xn_r == '0 || yn_r == '0) begin rn_r <= '0; rneg_r <= 1'b0; end
              else begin rn_r <= W'(1); rneg_r <= xneg_r ^ yneg_r; end
              st_r <= S_OUT;
            end else begin
              n_r <= p_r; d_r <= dd_r; neg_r <= xneg_r ^ yneg_r;
              a_r <= p_r; b_r <= dd_r; sh_r <= '0; g_r <= G_STRIP;
              st_r <= S_RR;
            end
          end else begin
            rn_r <= '0; rd_r <= '0; rneg_r <= 1'b0;
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            if (it_r.mode == MODE_CMP) begin
              out_res_num <= '0; out_res_den <= '0; out_overflow <= 1'b0;
              out_cmp_result <= cmp_r;
            end else begin
              ovf = (rn_r[W-1:NUM_WIDTH] != '0) ||
                    (rneg_r ? (rn_r[NUM_WIDTH-1:0] > {1'b1, {(NUM_WIDTH-1){1'b0}}})
                            : rn_r[NUM_WIDTH-1]) ||
                    (rd_r[W-1:NUM_WIDTH] != '0);
              out_res_num <= rneg_r ? NUM_WIDTH'(-rn_r) : rn_r[NUM_WIDTH-1:0];
              out_res_den <= rd_r[NUM_WIDTH-1:0];
              out_cmp_result <= CMP_EQ;
              out_overflow <= ovf;
            end
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (st_r == S_RA)) else $error("pop did not start work");
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (st_r == S_OUT)) else $error("result outside output state");
  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && it_r.mode == MODE_CMP) |-> (out_res_den == '0 && !out_overflow))
    else $error("compare result carries fraction");
`endif
endmodule
`default_nettype wire

### sv/rational_arith_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// rational add, subtract, multiply, divide and compare with gcd reduction.
// a front stage takes each beat into a two-entry queue; a back engine
// reduces both operands, forms the cross products on one 32x32 multiplier,
// then reduces a finite arithmetic result. a zero or special value skips
// the gcd; any other reduction is a binary gcd (one shift or subtract a
// cycle) plus two restoring divides, of the numerator and then of the
// denominator by the gcd. an item passes through the pop, the two operand
// reductions, the multiply steps, the combine step, the result reduction
// for finite add, subtract, multiply and divide, and the output step, which
// waits out any output stall. items are handled one at a time.
module rational_arith_unit (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [2:0]                    in_mode,
  input  wire  [rau_pkg::NUM_WIDTH-1:0] in_a_num,
  input  wire  [rau_pkg::NUM_WIDTH-1:0] in_a_den,
  input  wire  [rau_pkg::NUM_WIDTH-1:0] in_b_num,
  input  wire  [rau_pkg::NUM_WIDTH-1:0] in_b_den,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [rau_pkg::NUM_WIDTH-1:0] out_res_num,
  output logic [rau_pkg::NUM_WIDTH-1:0] out_res_den,
  output logic [1:0]                    out_cmp_result,
  output logic                          out_overflow
);
  import rau_pkg::*;
  logic q_valid, q_pop;
  work_t q_item;

  rau_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode, .in_a_num, .in_a_den,
    .in_b_num, .in_b_den, .q_valid, .q_pop, .q_item
  );
  rau_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_item, .out_valid, .out_stall,
    .out_res_num, .out_res_den, .out_cmp_result, .out_overflow
  );
endmodule
`default_nettype wire

### dv/rational_arith_unit_tb.sv
`timescale 1ns / 1ps
module rational_arith_unit_tb;
  import rau_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int IDLE_LIMIT = 50000;
  localparam int DRAIN_CYCLES = 1000;
  localparam int RANDOM_ITEMS = 1200;
  localparam logic [2:0] MODE_UNK5 = 3'd5;
  localparam logic [2:0] MODE_UNK6 = 3'd6;
  localparam logic [2:0] MODE_UNK7 = 3'd7;
  localparam logic [31:0] NUM_MAX = 32'h7fffffff;
  localparam logic [31:0] NUM_MIN = 32'h80000000;
  localparam logic [31:0] DEN_MAX = 32'hffffffff;

  typedef struct {
    bit neg;
    bit [127:0] n;
    bit [127:0] d;
  } rat_t;

  typedef struct {
    logic [31:0] num;
    logic [31:0] den;
    logic [1:0] cmp;
    logic ovf;
  } res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] in_mode = '0;
  logic [31:0] in_a_num = '0;
  logic [31:0] in_a_den = '0;
  logic [31:0] in_b_num = '0;
  logic [31:0] in_b_den = '0;
  logic out_valid;
  logic out_stall = 1;
  logic [31:0] out_res_num;
  logic [31:0] out_res_den;
  logic [1:0] out_cmp_result;
  logic out_overflow;

  res_t pending_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int ops_sent[8];
  int idle_cycles = 0;
  int stall_mode = 0;

  rational_arith_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_a_num(in_a_num), .in_a_den(in_a_den), .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_valid(out_valid), .out_stall(out_stall), .out_res_num(out_res_num),
    .out_res_den(out_res_den), .out_cmp_result(out_cmp_result), .out_overflow(out_overflow)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic rat_t mk_special(bit neg, bit [127:0] mag);
    rat_t f;
    f.neg = neg && (mag != 0);
    f.n = mag;
    f.d = '0;
    return f;
  endfunction

  function automatic bit [127:0] gcd_of(bit [127:0] a, bit [127:0] b);
    bit [127:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic rat_t reduce(rat_t f);
    bit [127:0] g;
    if (f.d == 0) return mk_special(f.neg, (f.n == 0) ? 0 : 1);
    g = gcd_of(f.n, f.d);
    f.n = f.n / g;
    f.d = f.d / g;
    if (f.n == 0) f.neg = 0;
    return f;
  endfunction

  function automatic rat_t load_operand(logic [31:0] num, logic [31:0] den, bit flip);
    rat_t f;
    logic [31:0] mag;
    f.neg = num[31];
    mag = f.neg ? -num : num;
    f.n = flip ? den : mag;
    f.d = flip ? mag : den;
    if (f.n == 0) f.neg = 0;
    return reduce(f);
  endfunction

  function automatic rat_t rat_negate(rat_t f);
    if (f.n != 0) f.neg = !f.neg;
    return f;
  endfunction

  function automatic rat_t rat_sum(rat_t x, rat_t y);
    rat_t r;
    bit [127:0] p, q;
    if (x.d == 0 || y.d == 0) begin
      if (x.d != 0) return y;
      if (y.d != 0) return x;
      if (x.neg == y.neg && x.n == y.n) return x;
      return mk_special(0, 0);
    end
    p = x.n * y.d;
    q = y.n * x.d;
    if (x.neg == y.neg) begin
      r.n = p + q;
      r.neg = x.neg;
    end else if (p >= q) begin
      r.n = p - q;
      r.neg = x.neg;
    end else begin
      r.n = q - p;
      r.neg = y.neg;
    end
    r.d = x.d * y.d;
    return reduce(r);
  endfunction

  function automatic rat_t rat_product(rat_t x, rat_t y);
    rat_t r;
    if (x.d == 0 || y.d == 0) begin
      if (x.n == 0 || y.n == 0) return mk_special(0, 0);
      return mk_special(x.neg != y.neg, 1);
    end
    r.neg = x.neg != y.neg;
    r.n = x.n * y.n;
    r.d = x.d * y.d;
    return reduce(r);
  endfunction

  function automatic res_t predict_result(logic [2:0] mode, logic [31:0] an, logic [31:0] ad,
                                          logic [31:0] bn, logic [31:0] bd);
    rat_t a, b, r;
    res_t e;
    bit [127:0] lim;
    a = load_operand(an, ad, 0);
    b = load_operand(bn, bd, mode == MODE_DIV);
    e.cmp = CMP_EQ;
    e.ovf = 0;
    if (mode == MODE_CMP) begin
      e.num = '0;
      e.den = '0;
      if (!(a.d == 0 && a.n == 0) && !(b.d == 0 && b.n == 0)) begin
        r = rat_sum(a, rat_negate(b));
        if (r.n != 0) e.cmp = r.neg ? CMP_LT : CMP_GT;
      end
      return e;
    end
    case (mode)
      MODE_ADD: r = rat_sum(a, b);
      MODE_SUB: r = rat_sum(a, rat_negate(b));
      MODE_MUL, MODE_DIV: r = rat_product(a, b);
      default: r = mk_special(0, 0);
    endcase
    lim = r.neg ? 128'h80000000 : 128'h7fffffff;
    e.ovf = (r.n > lim) || (r.d > 128'hffffffff);
    e.num = r.neg ? -r.n[31:0] : r.n[31:0];
    e.den = r.d[31:0];
    return e;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic send_op(logic [2:0] mode, logic [31:0] an, logic [31:0] ad,
                         logic [31:0] bn, logic [31:0] bd);
    int gap;
    in_valid <= 1;
    in_mode <= mode;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_result(mode, an, ad, bn, bd));
    ops_sent[mode]++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // often small values so the reduction has common factors to find
  function automatic logic [31:0] rand_num();
    case ($urandom_range(9))
      0: return NUM_MAX;
      1: return NUM_MIN;
      2: return 32'd0;
      3, 4: return 32'($urandom_range(24)) - 32'd12;
      5, 6: return 32'($urandom_range(2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_den();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return DEN_MAX;
      2, 3: return 32'($urandom_range(24, 1));
      4, 5: return 32'($urandom_range(2000, 1));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_arith_ops();
    send_op(MODE_ADD, 32'd3, 32'd4, -32'sd1, 32'd2);
    send_op(MODE_SUB, 32'd3, 32'd4, -32'sd1, 32'd2);
    send_op(MODE_MUL, 32'd6, 32'd4, -32'sd2, 32'd9);
    send_op(MODE_DIV, 32'd3, 32'd4, -32'sd1, 32'd2);
    send_op(MODE_SUB, 32'd1, 32'd2, 32'd2, 32'd4);
    send_op(MODE_MUL, 32'd0, 32'd7, -32'sd5, 32'd3);
  endtask

  task automatic test_extremes();
    send_op(MODE_MUL, NUM_MAX, 32'd1, NUM_MAX, 32'd1);
    send_op(MODE_ADD, NUM_MIN, 32'd1, NUM_MIN, 32'd1);
    send_op(MODE_SUB, NUM_MIN, DEN_MAX, NUM_MAX, 32'd1);
    send_op(MODE_MUL, 32'd1, DEN_MAX, 32'd1, DEN_MAX);
    send_op(MODE_DIV, NUM_MIN, 32'd1, -32'sd1, 32'd1);
    send_op(MODE_ADD, 32'd1, DEN_MAX, 32'd1, 32'hfffffffe);
  endtask

  task automatic test_specials();
    send_op(MODE_ADD, 32'd5, 32'd0, 32'd3, 32'd7);
    send_op(MODE_ADD, 32'd5, 32'd0, -32'sd2, 32'd0);
    send_op(MODE_SUB, 32'd5, 32'd0, 32'd9, 32'd0);
    send_op(MODE_MUL, 32'd0, 32'd0, 32'd4, 32'd0);
    send_op(MODE_MUL, -32'sd3, 32'd0, 32'd0, 32'd5);
    send_op(MODE_MUL, -32'sd3, 32'd0, 32'd4, 32'd0);
    send_op(MODE_DIV, 32'd3, 32'd2, 32'd0, 32'd5);
    send_op(MODE_DIV, 32'd3, 32'd2, -32'sd1, 32'd0);
    send_op(MODE_DIV, 32'd3, 32'd2, 32'd0, 32'd0);
  endtask

  task automatic test_compare_and_unknown();
    send_op(MODE_CMP, 32'd1, 32'd3, 32'd1, 32'd2);
    send_op(MODE_CMP, 32'd2, 32'd4, 32'd1, 32'd2);
    send_op(MODE_CMP, NUM_MAX, 32'd1, NUM_MIN, 32'd1);
    send_op(MODE_CMP, 32'd0, 32'd0, 32'd1, 32'd2);
    send_op(MODE_CMP, 32'd4, 32'd0, 32'd9, 32'd0);
    send_op(MODE_CMP, -32'sd4, 32'd0, 32'd9, DEN_MAX);
    send_op(MODE_UNK5, 32'd1, 32'd2, 32'd3, 32'd4);
    send_op(MODE_UNK6, NUM_MIN, DEN_MAX, 32'd0, 32'd0);
    send_op(MODE_UNK7, NUM_MAX, 32'd0, -32'sd1, 32'd1);
  endtask

  task automatic test_random_mix();
    logic [2:0] mode;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 300 == 0) stall_mode = $urandom_range(2);
      mode = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      send_op(mode, rand_num(), rand_den(), rand_num(), rand_den());
    end
    in_valid <= 0;
  endtask

  // result side: random stall, scoreboard check
  always @(posedge clk) begin
    res_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: num %h den %h cmp %0d ovf %0d",
                                       out_res_num, out_res_den, out_cmp_result, out_overflow);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_res_num !== exp_res.num || out_res_den !== exp_res.den ||
            out_cmp_result !== exp_res.cmp || out_overflow !== exp_res.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp num %h den %h cmp %0d ovf %0d, got num %h den %h cmp %0d ovf %0d",
                     exp_res.num, exp_res.den, exp_res.cmp, exp_res.ovf,
                     out_res_num, out_res_den, out_cmp_result, out_overflow);
        end
      end
    end
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(99) < 30);
      default: out_stall <= ($urandom_range(999) < 3) ? 1 : (out_stall && $urandom_range(99) < 97);
    endcase
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("rational_arith_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int drain;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    stall_mode <= 1;
    @(posedge clk);
    test_arith_ops();
    test_extremes();
    test_specials();
    test_compare_and_unknown();
    test_random_mix();
    while (pending_results.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < DRAIN_CYCLES) begin
      @(posedge clk);
      drain++;
    end
    $display("covered %0d results: add %0d sub %0d mul %0d div %0d cmp %0d unknown %0d",
             results_seen, ops_sent[MODE_ADD], ops_sent[MODE_SUB], ops_sent[MODE_MUL],
             ops_sent[MODE_DIV], ops_sent[MODE_CMP],
             ops_sent[MODE_UNK5] + ops_sent[MODE_UNK6] + ops_sent[MODE_UNK7]);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("rational_arith_unit regression: pass");
    end else begin
      $display("rational_arith_unit regression: fail");
    end
    $finish;
  end
endmodule

### files.f
sv/rau_pkg.sv
sv/rau_front.sv
sv/rau_back.sv
sv/rational_arith_unit.sv
dv/rational_arith_unit_tb.sv
